@@ sv/plf_pkg.sv @@
// Shared types and constants of the Playfair digraph cipher.
package plf_pkg;

	localparam int unsigned SIDE  = 5;
	localparam int unsigned CELLS = 25;
	localparam int unsigned ALPHA = 26;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] cell_t;
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_CLEAR  = 2'd0;
	localparam kind_t KIND_KEY    = 2'd1;
	localparam kind_t KIND_FINISH = 2'd2;
	localparam kind_t KIND_PLAIN  = 2'd3;

	localparam letter_t LETTER_I = 5'd8;
	localparam letter_t LETTER_J = 5'd9;
	localparam letter_t LETTER_X = 5'd23;
	localparam letter_t LETTER_Z = 5'd25;

	typedef struct packed {
		kind_t   kind;
		letter_t letter;
		logic    last;
	} in_payload_t;

	typedef struct packed {
		letter_t cipher_letter;
		logic    run_end;
	} out_payload_t;

	// Grid cells holding the two ciphertext letters of one digraph.
	typedef struct packed {
		cell_t first;
		cell_t second;
	} cell_pair_t;

endpackage

@@ sv/plf_stream_if.sv @@
// Valid/ready stream interface carrying one payload item per handshake.
interface plf_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/playfair_digraph_cipher.sv @@
// Top level of the Playfair digraph cipher engine.
//
// Channel text carries command items: clear grid, key letter, finish grid
// and plaintext letter (with a last flag). Channel code carries ciphertext
// letters, one per item, with run_end marking the last one of a command.
// A key letter or a clear is handled without leaving idle. A finish walks
// all 26 letters, one per cycle, and no item is taken until the walk ends.
// A plaintext letter that completes a digraph reads the letter-position
// memory, then the grid memory, and presents its two ciphertext letters
// one after the other through the output register; a doubled final letter
// repeats the digraph for four results. A letter that only becomes pending
// is taken at one per cycle; a digraph holds off new items until its last
// result, behind two dependent memory reads, is in the single output register.
// Reset clears the used-letter set (only J marked), fill count, pending
// letter and the output valid flag; the memories keep undefined contents
// until written. If the receiver stalls, the current result is held in the
// output register and the engine waits; the next command item may still be
// accepted once the last result of the previous one sits in that register.
module playfair_digraph_cipher (
	input logic                clk,
	input logic                arst_n,
	plf_stream_if.sink         text,
	plf_stream_if.source       code
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FILL  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_EMIT0 = 3'd3;
	localparam logic [2:0] ST_EMIT1 = 3'd4;

	logic [2:0]            state_q;
	logic [25:0]           used_q;
	plf_pkg::cell_t        fill_q;
	plf_pkg::letter_t      pend_q;
	logic                  pend_valid_q;
	plf_pkg::letter_t      scan_q;
	logic                  repeat_q;
	logic                  out_valid_q;
	plf_pkg::out_payload_t out_q;

	plf_pkg::in_payload_t  in_item;
	logic                  accept;
	logic                  slot_free;
	logic                  out_load;

	// Letter placement, shared by key letters and the finish sweep.
	plf_pkg::letter_t      place_ch;
	logic                  place_req;
	logic                  place_used;
	logic                  place_en;

	// Plaintext pairing decision.
	plf_pkg::letter_t      ch_norm;
	logic                  pair_emit;
	logic                  pair_repeat;
	plf_pkg::letter_t      pair_p;
	plf_pkg::letter_t      pair_q;
	plf_pkg::letter_t      pend_next;
	logic                  pend_valid_next;

	plf_pkg::cell_t        pos_a, pos_b;
	plf_pkg::cell_pair_t   cells;
	plf_pkg::letter_t      grid_a, grid_b;

	assign in_item    = text.payload;
	assign text.ready = (state_q == ST_IDLE);
	assign accept     = text.valid && text.ready;
	assign slot_free  = !out_valid_q || code.ready;
	// The output register takes a new letter in either emit state once it is free.
	assign out_load   = slot_free && ((state_q == ST_EMIT0) || (state_q == ST_EMIT1));

	assign code.valid   = out_valid_q;
	assign code.payload = out_q;

	always_comb begin
		place_ch  = (state_q == ST_FILL) ? scan_q : in_item.letter;
		place_req = (state_q == ST_FILL) ||
			(accept && (in_item.kind == plf_pkg::KIND_KEY));
		place_used = (place_ch < plf_pkg::letter_t'(plf_pkg::ALPHA)) ?
			used_q[place_ch] : 1'b1;
		place_en = place_req && !place_used &&
			(fill_q < plf_pkg::cell_t'(plf_pkg::CELLS));
	end

	always_comb begin
		if (in_item.letter > plf_pkg::LETTER_Z) ch_norm = plf_pkg::LETTER_Z;
		else if (in_item.letter == plf_pkg::LETTER_J) ch_norm = plf_pkg::LETTER_I;
		else ch_norm = in_item.letter;

		pair_emit       = 1'b0;
		pair_repeat     = 1'b0;
		pair_p          = ch_norm;
		pair_q          = plf_pkg::LETTER_X;
		pend_next       = pend_q;
		pend_valid_next = pend_valid_q;
		priority if (!pend_valid_q) begin
			if (in_item.last) begin
				pair_emit = 1'b1;
			end else begin
				pend_next       = ch_norm;
				pend_valid_next = 1'b1;
			end
		end else if (pend_q == ch_norm) begin
			// A doubled letter is split by X; with last set the second
			// letter pairs with X too, which gives the very same digraph.
			pair_emit   = 1'b1;
			pair_repeat = in_item.last;
			if (in_item.last) begin
				pend_next       = '0;
				pend_valid_next = 1'b0;
			end
		end else begin
			pair_emit       = 1'b1;
			pair_p          = pend_q;
			pair_q          = ch_norm;
			pend_next       = '0;
			pend_valid_next = 1'b0;
		end
	end

	// Letter positions: read at acceptance of a digraph-completing letter.
	plf_ram2r #(.DEPTH(plf_pkg::ALPHA), .WIDTH(5)) u_pos_mem (
		.clk    (clk),
		.we     (place_en),
		.waddr  (place_ch),
		.wdata  (fill_q),
		.re     (accept && (in_item.kind == plf_pkg::KIND_PLAIN) && pair_emit),
		.raddr0 (pair_p),
		.raddr1 (pair_q),
		.rdata0 (pos_a),
		.rdata1 (pos_b)
	);

	plf_cell_calc u_cell_calc (
		.pos_a (pos_a),
		.pos_b (pos_b),
		.cells (cells)
	);

	// Grid: read in the cycle after that, at the two cells chosen by the rules. The
	// read data is held until the next digraph, which also serves a repeat.
	plf_ram2r #(.DEPTH(plf_pkg::CELLS), .WIDTH(5)) u_grid_mem (
		.clk    (clk),
		.we     (place_en),
		.waddr  (fill_q),
		.wdata  (place_ch),
		.re     (state_q == ST_LOOK),
		.raddr0 (cells.first),
		.raddr1 (cells.second),
		.rdata0 (grid_a),
		.rdata1 (grid_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= 26'(1) << plf_pkg::LETTER_J;
			fill_q       <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			scan_q       <= '0;
			repeat_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (place_en) begin
				used_q[place_ch] <= 1'b1;
				fill_q           <= fill_q + 5'd1;
			end

			if (out_valid_q && code.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_item.kind)
							plf_pkg::KIND_CLEAR: begin
								used_q       <= 26'(1) << plf_pkg::LETTER_J;
								fill_q       <= '0;
								pend_q       <= '0;
								pend_valid_q <= 1'b0;
							end
							plf_pkg::KIND_KEY: begin
							end
							plf_pkg::KIND_FINISH: begin
								scan_q  <= '0;
								state_q <= ST_FILL;
							end
							plf_pkg::KIND_PLAIN: begin
								pend_q       <= pend_next;
								pend_valid_q <= pend_valid_next;
								repeat_q     <= pair_repeat;
								if (pair_emit) begin
									state_q <= ST_LOOK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					scan_q <= scan_q + 5'd1;
					if (scan_q == plf_pkg::letter_t'(plf_pkg::ALPHA - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOOK: begin
					state_q <= ST_EMIT0;
				end
				ST_EMIT0: begin
					if (slot_free) begin
						out_valid_q       <= 1'b1;
						out_q.cipher_letter <= grid_a;
						out_q.run_end     <= 1'b0;
						state_q           <= ST_EMIT1;
					end
				end
				ST_EMIT1: begin
					if (slot_free) begin
						out_valid_q       <= 1'b1;
						out_q.cipher_letter <= grid_b;
						out_q.run_end     <= !repeat_q;
						repeat_q          <= 1'b0;
						state_q           <= repeat_q ? ST_EMIT0 : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

@@ sv/plf_ram2r.sv @@
// Synchronous RAM with one write port and two registered read ports.
module plf_ram2r #(
	parameter int unsigned DEPTH = 26,
	parameter int unsigned WIDTH = 5
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

@@ sv/plf_cell_calc.sv @@
// Playfair rule selection: maps two letter positions to two ciphertext cells.
module plf_cell_calc (
	input  plf_pkg::cell_t      pos_a,
	input  plf_pkg::cell_t      pos_b,
	output plf_pkg::cell_pair_t cells
);
	function automatic logic [2:0] row_of(input plf_pkg::cell_t p);
		logic [2:0] r;
		if (p >= 5'd20) r = 3'd4;
		else if (p >= 5'd15) r = 3'd3;
		else if (p >= 5'd10) r = 3'd2;
		else if (p >= 5'd5) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

	function automatic plf_pkg::cell_t times5(input logic [2:0] r);
		return plf_pkg::cell_t'({r, 2'b00}) + plf_pkg::cell_t'(r);
	endfunction

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		return (v == 3'(plf_pkg::SIDE - 1)) ? 3'd0 : v + 3'd1;
	endfunction

	plf_pkg::cell_t pa, pb;
	logic [2:0] ar, ac, br, bc;

	always_comb begin
		// Positions outside the grid fall back to the first cell.
		pa = (pos_a >= plf_pkg::cell_t'(plf_pkg::CELLS)) ? '0 : pos_a;
		pb = (pos_b >= plf_pkg::cell_t'(plf_pkg::CELLS)) ? '0 : pos_b;
		ar = row_of(pa);
		br = row_of(pb);
		ac = 3'(pa - times5(ar));
		bc = 3'(pb - times5(br));
		priority if (ar == br) begin
			cells.first  = times5(ar) + plf_pkg::cell_t'(wrap_inc(ac));
			cells.second = times5(br) + plf_pkg::cell_t'(wrap_inc(bc));
		end else if (ac == bc) begin
			cells.first  = times5(wrap_inc(ar)) + plf_pkg::cell_t'(ac);
			cells.second = times5(wrap_inc(br)) + plf_pkg::cell_t'(bc);
		end else begin
			cells.first  = times5(ar) + plf_pkg::cell_t'(bc);
			cells.second = times5(br) + plf_pkg::cell_t'(ac);
		end
	end
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Playfair digraph cipher engine.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted item before the run is declared hung. The longest
	// legitimate quiet stretch is a sender gap plus the grid walk, or a
	// receiver stall plus the memory reads, so this is many times over.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Drain time at the end: covers a finish walk still in progress.
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned TARGET_ITEMS   = 250;

	logic clk = 1'b0;
	logic arst_n;

	plf_stream_if #(.payload_t(plf_pkg::in_payload_t))  text_if ();
	plf_stream_if #(.payload_t(plf_pkg::out_payload_t)) code_if ();

	// Local copies of the driven signals, so that every input is known from time zero.
	logic                 text_valid   = 1'b0;
	plf_pkg::in_payload_t text_payload = '0;
	logic                 code_ready   = 1'b0;

	assign text_if.valid   = text_valid;
	assign text_if.payload = text_payload;
	assign code_if.ready   = code_ready;

	playfair_digraph_cipher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.code   (code_if)
	);

	always #5 clk = ~clk;

	// Commands waiting to be offered, and ciphertext letters still owed by the block.
	plf_pkg::in_payload_t  command_queue[$];
	plf_pkg::out_payload_t cipher_expected[$];
	int unsigned           fail_count = 0;

	// -----------------------------------------------------------------------------
	// Predicted state of the cipher: the key square, where each letter sits in it,
	// which letters have been placed, how many cells are filled, and the plaintext
	// letter that is waiting for a partner.
	// -----------------------------------------------------------------------------
	plf_pkg::letter_t square[plf_pkg::CELLS];
	plf_pkg::cell_t   square_pos[plf_pkg::ALPHA];
	logic [25:0]      placed_set;
	int unsigned      square_fill;
	plf_pkg::letter_t held_letter;
	logic             held_valid;

	function automatic void clear_square();
		placed_set  = 26'd1 << plf_pkg::LETTER_J;
		square_fill = 0;
		held_letter = '0;
		held_valid  = 1'b0;
	endfunction

	// A letter goes into the next free cell unless it is out of range, already in
	// the square (J counts as placed from the start) or the square is full.
	function automatic void place_letter(int unsigned ch);
		if (ch >= plf_pkg::ALPHA || square_fill >= plf_pkg::CELLS)
			return;
		if (placed_set[ch])
			return;
		placed_set[ch]      = 1'b1;
		square[square_fill] = plf_pkg::letter_t'(ch);
		square_pos[ch]      = plf_pkg::cell_t'(square_fill);
		square_fill++;
	endfunction

	function automatic plf_pkg::letter_t square_at(int unsigned row, int unsigned col);
		return square[(row % plf_pkg::SIDE) * plf_pkg::SIDE + (col % plf_pkg::SIDE)];
	endfunction

	// Enciphers one digraph and queues its two ciphertext letters. The second one
	// carries run_end when it closes the results of the command.
	function automatic void queue_digraph(plf_pkg::letter_t p, plf_pkg::letter_t q,
		logic closes);
		int unsigned      pa, pb, ar, ac, br, bc;
		plf_pkg::letter_t c0, c1;
		pa = square_pos[p % plf_pkg::ALPHA];
		pb = square_pos[q % plf_pkg::ALPHA];
		if (pa >= plf_pkg::CELLS) pa = 0;
		if (pb >= plf_pkg::CELLS) pb = 0;
		ar = pa / plf_pkg::SIDE;
		ac = pa % plf_pkg::SIDE;
		br = pb / plf_pkg::SIDE;
		bc = pb % plf_pkg::SIDE;
		if (ar == br) begin
			// Same row, which also covers both letters in one cell: shift right.
			c0 = square_at(ar, ac + 1);
			c1 = square_at(br, bc + 1);
		end else if (ac == bc) begin
			c0 = square_at(ar + 1, ac);
			c1 = square_at(br + 1, bc);
		end else begin
			// Rectangle: each letter takes the corner in its own row.
			c0 = square_at(ar, bc);
			c1 = square_at(br, ac);
		end
		cipher_expected.insert(cipher_expected.size(),
			plf_pkg::out_payload_t'{cipher_letter: c0, run_end: 1'b0});
		cipher_expected.insert(cipher_expected.size(),
			plf_pkg::out_payload_t'{cipher_letter: c1, run_end: closes});
	endfunction

	// Updates the predicted state for one accepted command and queues its results.
	function automatic void predict_command(plf_pkg::in_payload_t item);
		plf_pkg::letter_t ch;
		ch = item.letter;
		case (item.kind)
			plf_pkg::KIND_CLEAR: begin
				clear_square();
			end
			plf_pkg::KIND_KEY: begin
				place_letter(ch);
			end
			plf_pkg::KIND_FINISH: begin
				for (int unsigned i = 0; i < plf_pkg::ALPHA; i++)
					place_letter(i);
			end
			default: begin
				// Plaintext: out-of-range letters read as Z and J reads as I.
				if (ch >= plf_pkg::ALPHA) ch = plf_pkg::LETTER_Z;
				if (ch == plf_pkg::LETTER_J) ch = plf_pkg::LETTER_I;
				if (!held_valid) begin
					if (item.last) begin
						queue_digraph(ch, plf_pkg::LETTER_X, 1'b1);
					end else begin
						held_letter = ch;
						held_valid  = 1'b1;
					end
				end else if (held_letter == ch) begin
					// A doubled letter is split by X; on the final letter the second copy
					// is padded too, giving four results.
					if (item.last) begin
						queue_digraph(held_letter, plf_pkg::LETTER_X, 1'b0);
						queue_digraph(ch, plf_pkg::LETTER_X, 1'b1);
						held_valid  = 1'b0;
						held_letter = '0;
					end else begin
						queue_digraph(held_letter, plf_pkg::LETTER_X, 1'b1);
					end
				end else begin
					queue_digraph(held_letter, ch, 1'b1);
					held_valid  = 1'b0;
					held_letter = '0;
				end
			end
		endcase
	endfunction

	// -----------------------------------------------------------------------------
	// Idle patterns. Each side draws a wait for every item; now and then it flips
	// into a calm spell in which it never waits, so that back-to-back traffic is
	// exercised as well as gaps on every phase of the engine's work.
	// -----------------------------------------------------------------------------
	bit text_calm = 1'b0;
	bit code_calm = 1'b0;

	function automatic int unsigned draw_wait(ref bit calm);
		if ($urandom_range(0, 23) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	// Driver: offers queued commands, holding each one until it is accepted.
	int unsigned text_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid   <= 1'b0;
			text_payload <= '0;
			text_wait    <= 0;
		end else begin
			if (text_valid && text_if.ready)
				predict_command(text_payload);
			if (!text_valid || text_if.ready) begin
				if (text_wait > 0) begin
					text_valid <= 1'b0;
					text_wait  <= text_wait - 1;
				end else if (command_queue.size() > 0) begin
					text_valid   <= 1'b1;
					text_payload <= command_queue.pop_front();
					text_wait    <= draw_wait(text_calm);
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes ciphertext letters with a randomly stalling ready and checks
	// each one against the oldest expectation.
	int unsigned code_wait;

	always @(posedge clk or negedge arst_n) begin
		int unsigned           stall;
		plf_pkg::out_payload_t want;
		if (!arst_n) begin
			code_ready <= 1'b0;
			code_wait  <= 0;
		end else if (code_if.valid && code_ready) begin
			if (cipher_expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual letter %0d run_end %0b",
					$time, code_if.payload.cipher_letter, code_if.payload.run_end);
				fail_count++;
			end else begin
				want = cipher_expected.pop_front();
				if (code_if.payload.cipher_letter !== want.cipher_letter) begin
					$display("%0t: cipher_letter mismatch, expected %0d, actual %0d",
						$time, want.cipher_letter, code_if.payload.cipher_letter);
					fail_count++;
				end
				if (code_if.payload.run_end !== want.run_end) begin
					$display("%0t: run_end mismatch, expected %0b, actual %0b",
						$time, want.run_end, code_if.payload.run_end);
					fail_count++;
				end
			end
			stall = draw_wait(code_calm);
			code_wait  <= stall;
			code_ready <= (stall == 0);
		end else if (code_wait > 0) begin
			code_wait  <= code_wait - 1;
			code_ready <= (code_wait == 1);
		end else begin
			code_ready <= 1'b1;
		end
	end

	// Watchdog: a long stretch with no accepted item on either side means a hang.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (text_valid && text_if.ready) ||
			(code_if.valid && code_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// -----------------------------------------------------------------------------
	// Stimulus.
	// -----------------------------------------------------------------------------
	function automatic void push_command(plf_pkg::kind_t kind, int unsigned letter,
		logic last);
		command_queue.insert(command_queue.size(),
			plf_pkg::in_payload_t'{kind: kind, letter: plf_pkg::letter_t'(letter),
			last: last});
	endfunction

	// Plaintext letters lean towards the interesting ones: repeats of the previous
	// letter (split by X), J, X itself and codes above Z.
	function automatic int unsigned pick_plain(int unsigned prev);
		case ($urandom_range(0, 15))
			0, 1:    return prev;
			2:       return plf_pkg::LETTER_J;
			3:       return plf_pkg::LETTER_X;
			4:       return $urandom_range(26, 31);
			default: return $urandom_range(0, 25);
		endcase
	endfunction

	function automatic int unsigned pick_key();
		case ($urandom_range(0, 11))
			0:       return $urandom_range(26, 31);
			1:       return plf_pkg::LETTER_J;
			default: return $urandom_range(0, 25);
		endcase
	endfunction

	initial begin
		int unsigned    n_keys;
		int unsigned    n_plain;
		int unsigned    prev;
		int unsigned    ch;
		plf_pkg::kind_t noise_kind;

		arst_n = 1'b0;
		clear_square();

		// Directed part. The square must be complete before any plaintext, as every
		// cell and position is then written; after that, stale contents are legal.
		// The key has a repeated letter, a J and an out-of-range code, all skipped.
		push_command(plf_pkg::KIND_KEY, 15, 1'b0);
		push_command(plf_pkg::KIND_KEY, 11, 1'b1);
		push_command(plf_pkg::KIND_KEY, 0, 1'b0);
		push_command(plf_pkg::KIND_KEY, 24, 1'b0);
		push_command(plf_pkg::KIND_KEY, 5, 1'b0);
		push_command(plf_pkg::KIND_KEY, 0, 1'b0);
		push_command(plf_pkg::KIND_KEY, plf_pkg::LETTER_J, 1'b0);
		push_command(plf_pkg::KIND_KEY, 31, 1'b0);
		push_command(plf_pkg::KIND_KEY, plf_pkg::LETTER_I, 1'b0);
		push_command(plf_pkg::KIND_KEY, 17, 1'b0);
		push_command(plf_pkg::KIND_FINISH, 31, 1'b1);
		// A then Y share the top row.
		push_command(plf_pkg::KIND_PLAIN, 0, 1'b0);
		push_command(plf_pkg::KIND_PLAIN, 24, 1'b0);
		// Doubled final letter: four results.
		push_command(plf_pkg::KIND_PLAIN, 0, 1'b0);
		push_command(plf_pkg::KIND_PLAIN, 0, 1'b1);
		// A lone final X pairs with the inserted X in the same cell.
		push_command(plf_pkg::KIND_PLAIN, plf_pkg::LETTER_X, 1'b1);
		// J reads as I, and a code above Z reads as Z.
		push_command(plf_pkg::KIND_PLAIN, plf_pkg::LETTER_J, 1'b0);
		push_command(plf_pkg::KIND_PLAIN, 30, 1'b0);
		// Doubled letter mid-message, then a different final letter.
		push_command(plf_pkg::KIND_PLAIN, 5, 1'b0);
		push_command(plf_pkg::KIND_PLAIN, 5, 1'b0);
		push_command(plf_pkg::KIND_PLAIN, 0, 1'b1);
		// A key letter into a full square is dropped; then rebuild with a new key.
		push_command(plf_pkg::KIND_KEY, 3, 1'b0);
		push_command(plf_pkg::KIND_CLEAR, 0, 1'b0);
		push_command(plf_pkg::KIND_KEY, plf_pkg::LETTER_Z, 1'b1);
		push_command(plf_pkg::KIND_FINISH, 0, 1'b0);

		// Random part: mostly well-formed messages, some after a rekeying, with some
		// noise commands, messages lacking a last flag and the odd plaintext run
		// over a half-built square. Every queued command counts towards the total.
		while (command_queue.size() < TARGET_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					push_command(plf_pkg::KIND_CLEAR, $urandom_range(0, 31),
						1'($urandom_range(0, 1)));
					n_keys = $urandom_range(0, 12);
					repeat (n_keys)
						push_command(plf_pkg::KIND_KEY, pick_key(), 1'($urandom_range(0, 1)));
					if ($urandom_range(0, 7) != 0) begin
						push_command(plf_pkg::KIND_FINISH, $urandom_range(0, 31),
							1'($urandom_range(0, 1)));
					end
				end
				2: begin
					repeat ($urandom_range(1, 3)) begin
						noise_kind = plf_pkg::kind_t'($urandom_range(0, 3));
						push_command(noise_kind, $urandom_range(0, 31),
							1'($urandom_range(0, 1)));
					end
				end
				default: ;
			endcase
			n_plain = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
			prev = $urandom_range(0, 25);
			for (int unsigned k = 0; k < n_plain; k++) begin
				ch = pick_plain(prev);
				push_command(plf_pkg::KIND_PLAIN, ch,
					(k == n_plain - 1) ? ($urandom_range(0, 5) != 0) : 1'b0);
				prev = ch;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Let every command be taken, every result arrive, then allow a finish walk
		// that may still be running to settle before the verdict.
		while (command_queue.size() != 0 || text_valid)
			@(negedge clk);
		while (cipher_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
